/* hw/rtl/gms_pkg.sv */
// gms_pkg: widths, register indexes and constants of the gain mixer.
// No dependencies; imported by the mixer top level and its checker.
package gms_pkg;

   localparam int VOICES     = 8;   // voice lanes taken into the mix, 1..8
   localparam int VOICE_PORTS = 8;  // voice fields on the request channel

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int COUNT_W    = 4;
   localparam int GAIN_SHIFT = 15;  // Q15

   // sample x gain is 33 bits signed; after the shift 18 bits hold any term
   localparam int PRODUCT_W  = SAMPLE_W + GAIN_W + 1;
   localparam int TERM_W     = PRODUCT_W - GAIN_SHIFT;
   // nine terms at most
   localparam int SUM_W      = TERM_W + 4;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

   localparam logic [GAIN_W-1:0]  MUSIC_GAIN_RESET   = 16'd9830;
   localparam logic [GAIN_W-1:0]  EFFECTS_GAIN_RESET = 16'd16384;
   localparam logic [COUNT_W-1:0] DRAIN_CHUNKS_RESET = 4'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MUSIC_GAIN     = 3'd0,
      CSR_EFFECTS_GAIN   = 3'd1,
      CSR_MUSIC_ENABLE   = 3'd2,
      CSR_EFFECTS_ENABLE = 3'd3,
      CSR_DRAIN_CHUNKS   = 3'd4
   } csr_index_type;

   localparam logic [SAMPLE_W-1:0] PEAK_LIMIT = 16'h8000;

endpackage

/* hw/rtl/gain_mix_saturate_drain.sv */
// gain_mix_saturate_drain: Q15 music and voice mixer with saturation, chunk
// peak tracking and an idle drain before power-down. Depends on gms_pkg.
//
//   channel | ports  | direction | moves
//   --------+--------+-----------+----------------------------------------
//   request | req_*  | in        | one sample position, music + 8 voices
//   result  | rsp_*  | out       | zero or one mixed sample per request
//   config  | csr_*  | in        | register write, index + data, no wait
//
// One request per cycle unless req_stall holds it; the term register holds the
// gained terms, then the output register the saturated mix and peak.
// Reset (synchronous) restores register defaults, powers the path up and
// clears the drain count and the peak. A stalled result holds the output
// register; the term register keeps filling until it, too, is occupied.
module gain_mix_saturate_drain
   import gms_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_music_sample,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_0,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_1,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_2,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_3,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_4,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_5,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_6,
   input  logic signed [SAMPLE_W-1:0]  req_voice_sample_7,
   input  logic                        req_music_active,
   input  logic [VOICE_PORTS-1:0]      req_voice_active,
   input  logic                        req_chunk_end,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic [SAMPLE_W-1:0]         rsp_chunk_peak,
   output logic                        rsp_powered,
   output logic                        rsp_last,

   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   // gained term: floor(sample * gain / 2^15); the slice of the signed
   // product is the arithmetic shift
   function automatic logic signed [TERM_W-1:0] gain_term(
      input logic signed [SAMPLE_W-1:0] sample,
      input logic [GAIN_W-1:0]          gain
   );
      logic signed [PRODUCT_W-1:0] product;
      product = PRODUCT_W'(sample) * $signed({1'b0, gain});
      return product[PRODUCT_W-1:GAIN_SHIFT];
   endfunction

   // ---------------------------------------------------------------- config
   logic [GAIN_W-1:0]  music_gain_ff,   music_gain_in;
   logic [GAIN_W-1:0]  effects_gain_ff, effects_gain_in;
   logic               music_enable_ff, music_enable_in;
   logic               effects_enable_ff, effects_enable_in;
   logic [COUNT_W-1:0] drain_chunks_ff, drain_chunks_in;

   always_comb begin
      music_gain_in     = music_gain_ff;
      effects_gain_in   = effects_gain_ff;
      music_enable_in   = music_enable_ff;
      effects_enable_in = effects_enable_ff;
      drain_chunks_in   = drain_chunks_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MUSIC_GAIN:     music_gain_in     = csr_write_data[GAIN_W-1:0];
            CSR_EFFECTS_GAIN:   effects_gain_in   = csr_write_data[GAIN_W-1:0];
            CSR_MUSIC_ENABLE:   music_enable_in   = csr_write_data[0];
            CSR_EFFECTS_ENABLE: effects_enable_in = csr_write_data[0];
            CSR_DRAIN_CHUNKS:   drain_chunks_in   = csr_write_data[COUNT_W-1:0];
            default: ;  // indexes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         music_gain_ff     <= MUSIC_GAIN_RESET;
         effects_gain_ff   <= EFFECTS_GAIN_RESET;
         music_enable_ff   <= 1'b1;
         effects_enable_ff <= 1'b1;
         drain_chunks_ff   <= DRAIN_CHUNKS_RESET;
      end else begin
         music_gain_ff     <= music_gain_in;
         effects_gain_ff   <= effects_gain_in;
         music_enable_ff   <= music_enable_in;
         effects_enable_ff <= effects_enable_in;
         drain_chunks_ff   <= drain_chunks_in;
      end
   end

   // ------------------------------------------------------------ flow control
   logic term_valid_ff, term_valid_in;
   logic rsp_valid_ff,  rsp_valid_in;
   logic out_ready;     // output register free this cycle
   logic term_ready;    // term register can take a request
   logic term_advance;  // term register hands its request on

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign term_ready   = !term_valid_ff || out_ready;
   assign term_advance = term_valid_ff && out_ready;
   assign req_stall    = !term_ready;

   // ------------------------------------------------------- stage 1: terms
   logic signed [SAMPLE_W-1:0] voice_sample [VOICE_PORTS];
   logic signed [TERM_W-1:0]   music_term_ff, music_term_in;
   logic signed [TERM_W-1:0]   voice_term_ff [VOICES];
   logic signed [TERM_W-1:0]   voice_term_in [VOICES];
   logic                       term_active_ff, term_active_in;
   logic                       term_last_ff;
   logic                       music_on;
   logic [VOICES-1:0]          voice_on;

   assign voice_sample[0] = req_voice_sample_0;
   assign voice_sample[1] = req_voice_sample_1;
   assign voice_sample[2] = req_voice_sample_2;
   assign voice_sample[3] = req_voice_sample_3;
   assign voice_sample[4] = req_voice_sample_4;
   assign voice_sample[5] = req_voice_sample_5;
   assign voice_sample[6] = req_voice_sample_6;
   assign voice_sample[7] = req_voice_sample_7;

   // a source not counted contributes a zero term; voices past VOICES never count
   always_comb begin
      music_on      = req_music_active && music_enable_ff;
      music_term_in = music_on ? gain_term(req_music_sample, music_gain_ff) : '0;
      for (int i = 0; i < VOICES; i++) begin
         voice_on[i]      = req_voice_active[i] && effects_enable_ff;
         voice_term_in[i] = voice_on[i] ? gain_term(voice_sample[i], effects_gain_ff)
                                        : '0;
      end
      term_active_in = music_on || (|voice_on);
   end

   assign term_valid_in = term_ready ? req_valid : term_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
      end else begin
         term_valid_ff <= term_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (term_ready && req_valid) begin
         music_term_ff  <= music_term_in;
         voice_term_ff  <= voice_term_in;
         term_active_ff <= term_active_in;
         term_last_ff   <= req_chunk_end;
      end
   end

   // --------------------------------------- stage 2: sum, saturate, drain
   logic                       power_on_ff,     power_on_in;
   logic [COUNT_W-1:0]         silent_count_ff, silent_count_in;
   logic [SAMPLE_W-1:0]        peak_level_ff,   peak_level_in;
   logic signed [SUM_W-1:0]    mix_sum;
   logic signed [SAMPLE_W-1:0] mix_sat;
   logic [SAMPLE_W-1:0]        mix_mag;
   logic [SAMPLE_W-1:0]        peak_new;
   logic                       emit;
   logic signed [SAMPLE_W-1:0] mixed_in;
   logic [SAMPLE_W-1:0]        peak_out_in;
   logic signed [SAMPLE_W-1:0] rsp_mixed_ff;
   logic [SAMPLE_W-1:0]        rsp_peak_ff;
   logic                       rsp_last_ff;

   always_comb begin
      mix_sum = SUM_W'(music_term_ff);
      for (int i = 0; i < VOICES; i++) begin
         mix_sum = mix_sum + SUM_W'(voice_term_ff[i]);
      end
      if (mix_sum > SAT_MAX) begin
         mix_sat = SAMPLE_W'(SAT_MAX);
      end else if (mix_sum < SAT_MIN) begin
         mix_sat = SAMPLE_W'(SAT_MIN);
      end else begin
         mix_sat = mix_sum[SAMPLE_W-1:0];
      end
      // unsigned negate: -32768 comes out as 32768, which the 16 bits hold
      mix_mag  = mix_sat[SAMPLE_W-1] ? SAMPLE_W'(-mix_sat) : mix_sat;
      peak_new = (mix_mag > peak_level_ff) ? mix_mag : peak_level_ff;
   end

   always_comb begin
      power_on_in     = power_on_ff;
      silent_count_in = silent_count_ff;
      peak_level_in   = peak_level_ff;
      emit            = 1'b0;
      mixed_in        = '0;
      peak_out_in     = peak_level_ff;
      if (term_advance) begin
         if (term_active_ff) begin
            // live source: wake if needed and emit the mix
            power_on_in     = 1'b1;
            silent_count_in = '0;
            emit            = 1'b1;
            mixed_in        = mix_sat;
            peak_out_in     = peak_new;
            peak_level_in   = term_last_ff ? '0 : peak_new;
         end else if (power_on_ff) begin
            if (silent_count_ff >= drain_chunks_ff) begin
               // drain done: power down, nothing out
               power_on_in     = 1'b0;
               silent_count_in = '0;
               peak_level_in   = '0;
            end else begin
               // drain: zero sample, count whole silent chunks
               emit = 1'b1;
               if (term_last_ff) begin
                  silent_count_in = silent_count_ff + 1'b1;
                  peak_level_in   = '0;
               end
            end
         end
         // powered down and idle: the request is swallowed
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_on_ff     <= 1'b1;
         silent_count_ff <= '0;
         peak_level_ff   <= '0;
      end else begin
         power_on_ff     <= power_on_in;
         silent_count_ff <= silent_count_in;
         peak_level_ff   <= peak_level_in;
      end
   end

   // ---------------------------------------------------- output register
   assign rsp_valid_in = out_ready ? (term_advance && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (term_advance && emit) begin
         rsp_mixed_ff <= mixed_in;
         rsp_peak_ff  <= peak_out_in;
         rsp_last_ff  <= term_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_mixed_ff;
   assign rsp_chunk_peak   = rsp_peak_ff;
   assign rsp_powered      = 1'b1;  // a result only leaves while powered
   assign rsp_last         = rsp_last_ff;

endmodule

/* hw/rtl/gms_checker.sv */
// gms_checker: port-level assertions on the mixer result channel, bound to
// gain_mix_saturate_drain. Depends on gms_pkg.
module gms_checker
   import gms_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_mixed_sample,
   input logic [SAMPLE_W-1:0]        rsp_chunk_peak,
   input logic                       rsp_powered
);

   logic [SAMPLE_W-1:0] mix_mag;

   assign mix_mag = rsp_mixed_sample[SAMPLE_W-1] ? SAMPLE_W'(-rsp_mixed_sample)
                                                 : rsp_mixed_sample;

   // peak covers the sample it goes out with
   peak_covers_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chunk_peak >= mix_mag)
      else $error("chunk peak below the magnitude of its sample");

   peak_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chunk_peak <= PEAK_LIMIT)
      else $error("chunk peak above full scale");

   powered_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_powered)
      else $error("result sent while powered down");

   stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mixed_sample)
                                 && $stable(rsp_chunk_peak))
      else $error("stalled result changed");

endmodule

bind gain_mix_saturate_drain gms_checker u_gms_checker (.*);

/* verif/tb.sv */
// tb: self-checking bench for gain_mix_saturate_drain. Directed and random sample
// positions, a cycle-free predictor of the mix and a queue of expected mixes.
// Depends on gms_pkg and gain_mix_saturate_drain only.
module tb;
   import gms_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int SETTLE_CYCLES  = 10;      // two-stage pipe plus margin for silent positions
   localparam int LONG_HOLD      = 60;      // long receiver hold-off, in cycles
   localparam int PHASE_ITEMS    = 40;      // least number of sounding positions per random phase
   localparam int RANDOM_PHASES  = 9;
   localparam int TIMEOUT_CYCLES = 200000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   // one sample position as offered on the request channel
   typedef struct packed {
      sample_type                           music;
      logic [VOICE_PORTS-1:0][SAMPLE_W-1:0] voice;
      logic                                 music_active;
      logic [VOICE_PORTS-1:0]               voice_active;
      logic                                 chunk_end;
   } position_type;

   // one mixed sample as seen on the result channel
   typedef struct packed {
      sample_type          mixed;
      logic [SAMPLE_W-1:0] peak;
      logic                powered;
      logic                last;
   } mix_type;

   // ---------------------------------------------------------------- ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   sample_type             req_music_sample   = '0;
   sample_type             req_voice_sample_0 = '0;
   sample_type             req_voice_sample_1 = '0;
   sample_type             req_voice_sample_2 = '0;
   sample_type             req_voice_sample_3 = '0;
   sample_type             req_voice_sample_4 = '0;
   sample_type             req_voice_sample_5 = '0;
   sample_type             req_voice_sample_6 = '0;
   sample_type             req_voice_sample_7 = '0;
   logic                   req_music_active = 1'b0;
   logic [VOICE_PORTS-1:0] req_voice_active = '0;
   logic                   req_chunk_end    = 1'b0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   sample_type             rsp_mixed_sample;
   logic [SAMPLE_W-1:0]    rsp_chunk_peak;
   logic                   rsp_powered;
   logic                   rsp_last;

   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   gain_mix_saturate_drain dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- bench state
   position_type positions_to_send[$];   // requests waiting for the driver
   mix_type      expected_mix[$];        // predicted mixes, oldest first
   int        positions_queued = 0;   // requests handed to the driver
   int        positions_taken  = 0;   // requests accepted by the mixer
   int        sounding_queued  = 0;
   int        errors           = 0;
   logic      req_taken        = 1'b0;   // request accepted at the last rising edge

   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   int        holds_asked    = 0;        // long hold-offs requested by the stimulus
   int        holds_done     = 0;
   int        hold_left      = 0;

   // ---------------------------------------------------------------- predictor state
   logic [GAIN_W-1:0]   gain_music   = MUSIC_GAIN_RESET;
   logic [GAIN_W-1:0]   gain_effects = EFFECTS_GAIN_RESET;
   logic                en_music     = 1'b1;
   logic                en_effects   = 1'b1;
   logic [COUNT_W-1:0]  drain_target = DRAIN_CHUNKS_RESET;
   logic                path_powered = 1'b1;
   logic [COUNT_W-1:0]  silent_chunks = '0;
   logic [SAMPLE_W-1:0] peak_hold     = '0;

   // Mix one accepted position. Returns 1 when the mixer emits a sample for it.
   function automatic bit mix_position(input position_type p, output mix_type r);
      longint              sum;
      longint              clipped;
      int                  counted;
      logic [SAMPLE_W-1:0] mag;
      sum     = 0;
      counted = 0;
      r       = '0;
      // Q15 scaling: >>> on a signed product floors toward minus infinity
      if (p.music_active && en_music) begin
         sum += longint'($signed(p.music)) * longint'(gain_music) >>> GAIN_SHIFT;
         counted++;
      end
      if (en_effects) begin
         for (int i = 0; i < VOICES; i++) begin
            if (p.voice_active[i]) begin
               sum += longint'($signed(p.voice[i])) * longint'(gain_effects) >>> GAIN_SHIFT;
               counted++;
            end
         end
      end

      if (counted == 0) begin
         if (!path_powered)
            return 1'b0;                        // dark and idle: nothing happens
         if (silent_chunks >= drain_target) begin
            // drain complete: power down, swallow this position
            path_powered  = 1'b0;
            silent_chunks = '0;
            peak_hold     = '0;
            return 1'b0;
         end
         r.peak    = peak_hold;                 // silence keeps the chunk peak
         r.powered = 1'b1;
         r.last    = p.chunk_end;
         if (p.chunk_end) begin
            silent_chunks = silent_chunks + 1'b1;
            peak_hold     = '0;
         end
         return 1'b1;
      end

      // any counted source wakes the path and restarts the drain
      path_powered  = 1'b1;
      silent_chunks = '0;
      clipped = (sum > SAT_MAX) ? SAT_MAX : (sum < SAT_MIN) ? SAT_MIN : sum;
      mag     = SAMPLE_W'((clipped < 0) ? -clipped : clipped);
      if (mag > peak_hold)
         peak_hold = mag;
      r.mixed   = clipped[SAMPLE_W-1:0];
      r.peak    = peak_hold;
      r.powered = 1'b1;
      r.last    = p.chunk_end;
      if (p.chunk_end)
         peak_hold = '0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- driver
   // Changes the request on the falling edge, only once the previous one is taken.
   always @(negedge clock) begin : driver
      position_type pos;
      if (!req_valid || req_taken) begin
         if (positions_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            pos = positions_to_send.pop_front();
            req_music_sample   <= pos.music;
            req_voice_sample_0 <= pos.voice[0];
            req_voice_sample_1 <= pos.voice[1];
            req_voice_sample_2 <= pos.voice[2];
            req_voice_sample_3 <= pos.voice[3];
            req_voice_sample_4 <= pos.voice[4];
            req_voice_sample_5 <= pos.voice[5];
            req_voice_sample_6 <= pos.voice[6];
            req_voice_sample_7 <= pos.voice[7];
            req_music_active   <= pos.music_active;
            req_voice_active   <= pos.voice_active;
            req_chunk_end      <= pos.chunk_end;
            req_valid          <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: random stalls, or a long hold-off when asked for.
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left  <= LONG_HOLD - 1;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor
   // Samples both channels on the rising edge: checks results, predicts requests.
   always @(posedge clock) begin : monitor
      mix_type      want;
      position_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mix.size() == 0) begin
               $error("mixed sample %0d with no request outstanding", rsp_mixed_sample);
               errors++;
            end else begin
               want = expected_mix.pop_front();
               if (rsp_mixed_sample !== want.mixed) begin
                  $error("mixed_sample: expected %0d, got %0d", want.mixed, rsp_mixed_sample);
                  errors++;
               end
               if (rsp_chunk_peak !== want.peak) begin
                  $error("chunk_peak: expected %0d, got %0d", want.peak, rsp_chunk_peak);
                  errors++;
               end
               if (rsp_powered !== want.powered) begin
                  $error("powered: expected %0b, got %0b", want.powered, rsp_powered);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errors++;
               end
            end
         end

         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.music        = req_music_sample;
            seen.voice        = {req_voice_sample_7, req_voice_sample_6, req_voice_sample_5,
                                 req_voice_sample_4, req_voice_sample_3, req_voice_sample_2,
                                 req_voice_sample_1, req_voice_sample_0};
            seen.music_active = req_music_active;
            seen.voice_active = req_voice_active;
            seen.chunk_end    = req_chunk_end;
            positions_taken++;
            if (mix_position(seen, want))
               expected_mix.push_back(want);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   function automatic sample_type pick_sample();
      case ($urandom_range(7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return sample_type'(int'($urandom_range(31)) - 16);   // near zero, both signs
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic void push_position(input position_type p);
      positions_to_send.push_back(p);
      positions_queued++;
   endfunction

   // directed position: every voice lane carries the same sample
   function automatic void push_fixed(sample_type m, sample_type v, logic ma,
                                      logic [VOICE_PORTS-1:0] va, logic ce);
      position_type p;
      p.music        = m;
      p.voice        = {VOICE_PORTS{v}};
      p.music_active = ma;
      p.voice_active = va;
      p.chunk_end    = ce;
      push_position(p);
   endfunction

   // Queue whole chunks. Sounding chunks carry live flags; silent ones carry
   // random samples with every flag clear. A stray chunk end now and then
   // breaks the chunk framing.
   function automatic void queue_chunks(int chunks, bit sounding);
      position_type p;
      int           len;
      repeat (chunks) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
         for (int k = 0; k < len; k++) begin
            p.music = pick_sample();
            for (int i = 0; i < VOICE_PORTS; i++)
               p.voice[i] = pick_sample();
            p.chunk_end = (k == len - 1) || ($urandom_range(19) == 0);
            if (sounding) begin
               p.music_active = ($urandom_range(99) < 70);
               case ($urandom_range(3))
                  0:       p.voice_active = '0;
                  1:       p.voice_active = VOICE_PORTS'(1) << $urandom_range(VOICE_PORTS - 1);
                  2:       p.voice_active = '1;
                  default: p.voice_active = VOICE_PORTS'($urandom);
               endcase
            end else begin
               p.music_active = 1'b0;
               p.voice_active = '0;
            end
            push_position(p);
         end
         if (sounding)
            sounding_queued += len;
      end
   endfunction

   // Register write on the falling edge; the mixer takes it on the next rising edge.
   // The predictor follows at once since the mixer is idle.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_MUSIC_GAIN:     gain_music   = data[GAIN_W-1:0];
         CSR_EFFECTS_GAIN:   gain_effects = data[GAIN_W-1:0];
         CSR_MUSIC_ENABLE:   en_music     = data[0];
         CSR_EFFECTS_ENABLE: en_effects   = data[0];
         CSR_DRAIN_CHUNKS:   drain_target = data[COUNT_W-1:0];
         default: ;                          // spare index: write is dropped
      endcase
      @(negedge clock);
   endtask

   // Sender pause: every request taken, every mix back, then let the pipe settle
   // (silent positions leave no result to wait for).
   task automatic wait_quiet();
      while (positions_taken != positions_queued || expected_mix.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- test sequence
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] mg, eg, me, ee, dc;
      int                    start;

      // sender idles lightly, receiver stalls heavily
      send_idle_pct  = 24;
      recv_stall_pct = 67;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, at the reset register values.
      // full scale positive on every source: clips high
      push_fixed(SAMPLE_MAX, SAMPLE_MAX, 1'b1, '1, 1'b0);
      // full scale negative: clips low, peak reaches 32768, chunk closes
      push_fixed(SAMPLE_MIN, SAMPLE_MIN, 1'b1, '1, 1'b1);
      // small negative music term floors to -1
      push_fixed(-1, 0, 1'b1, '0, 1'b0);
      // music alone, voice samples present but not live
      push_fixed(SAMPLE_MAX, SAMPLE_MIN, 1'b1, '0, 1'b0);
      // top voice alone
      push_fixed(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 8'h80, 1'b0);
      push_fixed(12345, -2345, 1'b1, 8'h55, 1'b0);
      push_fixed(-12345, 2345, 1'b0, 8'hAA, 1'b0);
      // counted sources that mix to zero, chunk end
      push_fixed(0, 0, 1'b1, '1, 1'b1);
      push_fixed(1000, 0, 1'b1, '0, 1'b0);
      // silent position mid-chunk: zero out, peak carried
      push_fixed(SAMPLE_MAX, SAMPLE_MAX, 1'b0, '0, 1'b0);
      // drain: default count of silent chunk ends
      repeat (4) push_fixed(SAMPLE_MIN, SAMPLE_MIN, 1'b0, '0, 1'b1);
      // next silent position powers down; after that the path stays dark
      push_fixed(0, 0, 1'b0, '0, 1'b0);
      push_fixed(SAMPLE_MAX, SAMPLE_MAX, 1'b0, '0, 1'b1);
      // wake on a single live voice
      push_fixed(-300, 4000, 1'b0, 8'h01, 1'b1);
      push_fixed(SAMPLE_MIN, 1, 1'b1, 8'h01, 1'b0);
      wait_quiet();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // idling: light sender / heavy receiver, then swapped, then none at all
         if (phase < 3) begin
            send_idle_pct  = 24;
            recv_stall_pct = 67;
         end else if (phase < 6) begin
            send_idle_pct  = 67;
            recv_stall_pct = 24;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         // register values: random upper bits on the narrow registers too
         mg = CSR_DATA_W'($urandom);
         eg = CSR_DATA_W'($urandom);
         me = CSR_DATA_W'($urandom);
         ee = CSR_DATA_W'($urandom);
         dc = CSR_DATA_W'($urandom);
         case (phase)
            0: begin                          // max gains, no drain at all
               mg = '1; eg = '1; me[0] = 1'b1; ee[0] = 1'b1; dc[COUNT_W-1:0] = '0;
            end
            1: begin                          // zero gains, longest drain
               mg = '0; eg = '0; me[0] = 1'b1; ee[0] = 1'b1; dc[COUNT_W-1:0] = '1;
            end
            2: begin me[0] = 1'b0; ee[0] = 1'b1; end
            3: begin me[0] = 1'b1; ee[0] = 1'b0; end
            4: begin                          // unity gain
               mg = 16'h8000; eg = 16'h8000; me[0] = 1'b1; ee[0] = 1'b1;
               dc[COUNT_W-1:0] = 4'd1;
            end
            5: begin                          // both buses gated: only drain and sleep
               me[0] = 1'b0; ee[0] = 1'b0; dc[COUNT_W-1:0] = 4'd2;
            end
            default: begin
               me[0] = ($urandom_range(3) != 0);
               ee[0] = ($urandom_range(3) != 0);
            end
         endcase
         write_reg(CSR_MUSIC_GAIN, mg);
         write_reg(CSR_EFFECTS_GAIN, eg);
         write_reg(CSR_MUSIC_ENABLE, me);
         write_reg(CSR_EFFECTS_ENABLE, ee);
         write_reg(CSR_DRAIN_CHUNKS, dc);
         // spare indexes must leave every register alone
         for (int k = CSR_DRAIN_CHUNKS + 1; k < 2 ** CSR_INDEX_W; k++)
            write_reg(CSR_INDEX_W'(k), CSR_DATA_W'($urandom));
         csr_write_enable <= 1'b0;

         // long receiver hold-off while the sender keeps offering requests
         if (phase == 1 || phase == 7)
            holds_asked++;

         // bursts of sounding chunks, often followed by a silent run long enough
         // to drain, power down and then wake again
         start = sounding_queued;
         while (sounding_queued - start < PHASE_ITEMS) begin
            queue_chunks($urandom_range(4, 1), 1'b1);
            if ($urandom_range(99) < 60)
               queue_chunks($urandom_range(drain_target + 3), 1'b0);
         end
         wait_quiet();
      end

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("tb: failure");
      $finish;
   end

endmodule
